>>> design/red_pkg.sv
// Shared types and constants for the row Euclidean distance block.
package red_pkg;

	localparam int ELEM_W  = 16;
	localparam int MAG_W   = 16;
	localparam int SQ_W    = 32;
	localparam int SUM_W   = 40;
	localparam int DIST_W  = 20;
	localparam int CFG_W   = 7;
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = 2;
	localparam int QLVL_W  = 3;
	localparam int REM_W   = 22;
	localparam int ITER_W  = 5;

	localparam logic [CFG_W-1:0]  COLUMN_COUNT_RST = 7'd64;
	localparam logic [SUM_W-1:0]  SUM_MAX          = {SUM_W{1'b1}};
	localparam logic [ITER_W-1:0] ITER_LAST        = 5'd19;
	localparam logic [QLVL_W-1:0] QLVL_FULL        = 3'd4;

	// Per-item control flowing down the front pipeline
	typedef struct packed {
		logic valid;
		logic clr;
		logic last;
	} red_ctl_t;

	// Row sum handed from the front to the queue
	typedef struct packed {
		logic             valid;
		logic [SUM_W-1:0] sum;
	} red_push_t;

	// Queue fill status seen by both sides
	typedef struct packed {
		logic [QLVL_W-1:0] level;
	} red_qstat_t;

	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_RUN,
		SQ_HOLD
	} red_sq_state_t;

	// Square root sequencer controls
	typedef struct packed {
		logic q_pop;
		logic start;
		logic step;
		logic give;
	} red_sq_ctl_t;

endpackage

>>> design/red_front.sv
// Front part: item intake, target store, squared difference pipeline and row accumulator.
module red_front #(
	parameter int MAX_COLUMNS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic                            mode,
	input  logic signed [red_pkg::ELEM_W-1:0] element,
	input  logic                            cfg_write,
	input  logic [red_pkg::CFG_W-1:0]       cfg_data,
	input  red_pkg::red_qstat_t             qstat,
	output red_pkg::red_push_t              qpush
);

	localparam int PW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int CW = ($clog2(MAX_COLUMNS + 1) > red_pkg::CFG_W) ?
		$clog2(MAX_COLUMNS + 1) : red_pkg::CFG_W;

	logic [red_pkg::CFG_W-1:0]  column_count_q;
	logic [PW-1:0]              load_pos_q;
	logic [PW-1:0]              col_pos_q;
	logic [red_pkg::ELEM_W-1:0] target_mem [MAX_COLUMNS];

	logic [CW-1:0] cfg_ext;
	logic [CW-1:0] eff;
	logic [CW-1:0] lp_ext;
	logic [CW-1:0] lp;
	logic [CW-1:0] cp_ext;
	logic [CW-1:0] cp;
	logic          lp_wrap;
	logic          cp_last;
	logic          accept;

	red_pkg::red_ctl_t           ctl_s1;
	red_pkg::red_ctl_t           ctl_s2;
	red_pkg::red_ctl_t           ctl_s3;
	logic [red_pkg::ELEM_W-1:0]  elem_s1;
	logic [red_pkg::ELEM_W-1:0]  tgt_s1;
	logic [red_pkg::MAG_W-1:0]   mag_s2;
	logic [red_pkg::SQ_W-1:0]    sq_s3;
	logic [red_pkg::SUM_W-1:0]   sum_q;

	logic signed [red_pkg::ELEM_W:0] diff;
	logic [red_pkg::ELEM_W:0]        mag;
	logic [red_pkg::SUM_W:0]         sum_add;
	logic [red_pkg::SUM_W-1:0]       sum_sat;
	logic [3:0]                      occupancy;

	// Hold the column count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= red_pkg::COLUMN_COUNT_RST;
		end else if (cfg_write) begin
			column_count_q <= cfg_data;
		end
	end

	// Clamp the column count and the two positions into range
	always_comb begin
		cfg_ext = CW'(column_count_q);
		if (cfg_ext == '0) begin
			eff = CW'(1);
		end else if (cfg_ext > CW'(MAX_COLUMNS)) begin
			eff = CW'(MAX_COLUMNS);
		end else begin
			eff = cfg_ext;
		end
		lp_ext  = CW'(load_pos_q);
		cp_ext  = CW'(col_pos_q);
		lp      = (lp_ext >= eff) ? eff - CW'(1) : lp_ext;
		cp      = (cp_ext >= eff) ? eff - CW'(1) : cp_ext;
		lp_wrap = (lp + CW'(1)) >= eff;
		cp_last = (cp + CW'(1)) >= eff;
	end

	// Count row results still in flight plus those already queued
	always_comb begin
		occupancy = 4'(qstat.level)
			+ 4'(ctl_s1.valid & ctl_s1.last & ~ctl_s1.clr)
			+ 4'(ctl_s2.valid & ctl_s2.last & ~ctl_s2.clr)
			+ 4'(ctl_s3.valid & ctl_s3.last & ~ctl_s3.clr);
		full = occupancy >= 4'(red_pkg::QLVL_FULL);
	end

	assign accept = push & ~full;

	// Advance load and column positions on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_pos_q <= '0;
			col_pos_q  <= '0;
		end else if (accept) begin
			if (!mode) begin
				load_pos_q <= lp_wrap ? '0 : PW'(lp + CW'(1));
				col_pos_q  <= '0;
			end else begin
				col_pos_q  <= cp_last ? '0 : PW'(cp + CW'(1));
			end
		end
	end

	// Write target on a load, read it on a feature
	always_ff @(posedge clk) begin
		if (accept && !mode) begin
			target_mem[lp[PW-1:0]] <= element;
		end
		if (accept && mode) begin
			tgt_s1 <= target_mem[cp[PW-1:0]];
		end
		if (accept) begin
			elem_s1 <= element;
		end
	end

	// Absolute difference
	always_comb begin
		diff = $signed({elem_s1[red_pkg::ELEM_W-1], elem_s1})
			- $signed({tgt_s1[red_pkg::ELEM_W-1], tgt_s1});
		mag  = diff[red_pkg::ELEM_W] ? (red_pkg::ELEM_W+1)'(-diff) : diff;
	end

	// Advance control through the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s1.valid <= accept;
			ctl_s1.clr   <= ~mode;
			ctl_s1.last  <= cp_last;
			ctl_s2       <= ctl_s1;
			ctl_s3       <= ctl_s2;
		end
	end

	// Register magnitude, then its square
	always_ff @(posedge clk) begin
		mag_s2 <= mag[red_pkg::MAG_W-1:0];
		sq_s3  <= red_pkg::SQ_W'(mag_s2) * red_pkg::SQ_W'(mag_s2);
	end

	// Saturating accumulate
	always_comb begin
		sum_add = {1'b0, sum_q} + (red_pkg::SUM_W+1)'(sq_s3);
		sum_sat = sum_add[red_pkg::SUM_W] ? red_pkg::SUM_MAX : sum_add[red_pkg::SUM_W-1:0];
		qpush.valid = ctl_s3.valid & ~ctl_s3.clr & ctl_s3.last;
		qpush.sum   = sum_sat;
	end

	// Drop the sum on a load or at row end, otherwise take the new running total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctl_s3.valid) begin
			if (ctl_s3.clr || ctl_s3.last) begin
				sum_q <= '0;
			end else begin
				sum_q <= sum_sat;
			end
		end
	end

endmodule

>>> design/red_queue.sv
// Short queue of finished row sums between the front and the square root back part.
module red_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  red_pkg::red_push_t         qpush,
	input  logic                       q_pop,
	output red_pkg::red_qstat_t        qstat,
	output logic [red_pkg::SUM_W-1:0]  q_sum
);

	logic [red_pkg::SUM_W-1:0]  entry_q [red_pkg::QDEPTH];
	logic [red_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [red_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [red_pkg::QLVL_W-1:0] level_q;

	// Store an incoming sum
	always_ff @(posedge clk) begin
		if (qpush.valid) begin
			entry_q[wr_ptr_q] <= qpush.sum;
		end
	end

	// Advance pointers and track fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (qpush.valid) begin
				wr_ptr_q <= wr_ptr_q + red_pkg::QPTR_W'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + red_pkg::QPTR_W'(1);
			end
			level_q <= level_q + red_pkg::QLVL_W'(qpush.valid) - red_pkg::QLVL_W'(q_pop);
		end
	end

	assign q_sum       = entry_q[rd_ptr_q];
	assign qstat.level = level_q;

endmodule

>>> design/red_back.sv
// Back part: digit-by-digit integer square root and the result register.
module red_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  red_pkg::red_qstat_t        qstat,
	input  logic [red_pkg::SUM_W-1:0]  q_sum,
	output logic                       q_pop,
	input  logic                       pop,
	output logic                       empty,
	output logic [red_pkg::DIST_W-1:0] distance
);

	red_pkg::red_sq_state_t state_q;
	red_pkg::red_sq_state_t state_d;
	red_pkg::red_sq_ctl_t   ctl;

	logic [red_pkg::SUM_W-1:0]  v_q;
	logic [red_pkg::REM_W-1:0]  rem_q;
	logic [red_pkg::DIST_W-1:0] root_q;
	logic [red_pkg::ITER_W-1:0] iter_q;
	logic                       out_valid_q;
	logic [red_pkg::DIST_W-1:0] distance_q;

	logic [red_pkg::REM_W-1:0]  rem_sh;
	logic [red_pkg::REM_W-1:0]  trial;
	logic                       fits;
	logic                       out_take;

	assign out_take = pop & out_valid_q;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			red_pkg::SQ_IDLE: begin
				if (qstat.level != '0) begin
					state_d = red_pkg::SQ_RUN;
				end
			end
			red_pkg::SQ_RUN: begin
				if (iter_q == '0) begin
					state_d = red_pkg::SQ_HOLD;
				end
			end
			red_pkg::SQ_HOLD: begin
				if (!out_valid_q || out_take) begin
					state_d = red_pkg::SQ_IDLE;
				end
			end
			default: begin
				state_d = red_pkg::SQ_IDLE;
			end
		endcase
	end

	// Sequencer outputs
	always_comb begin
		ctl = '0;
		case (state_q)
			red_pkg::SQ_IDLE: begin
				ctl.q_pop = qstat.level != '0;
				ctl.start = qstat.level != '0;
			end
			red_pkg::SQ_RUN: begin
				ctl.step = 1'b1;
			end
			red_pkg::SQ_HOLD: begin
				ctl.give = !out_valid_q || out_take;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= red_pkg::SQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// One root bit per step: bring down two radicand bits and try to subtract
	always_comb begin
		rem_sh = {rem_q[red_pkg::REM_W-3:0], v_q[red_pkg::SUM_W-1 -: 2]};
		trial  = {root_q, 2'b01};
		fits   = rem_sh >= trial;
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			v_q    <= q_sum;
			rem_q  <= '0;
			root_q <= '0;
			iter_q <= red_pkg::ITER_LAST;
		end else if (ctl.step) begin
			v_q    <= {v_q[red_pkg::SUM_W-3:0], 2'b00};
			rem_q  <= fits ? rem_sh - trial : rem_sh;
			root_q <= {root_q[red_pkg::DIST_W-2:0], fits};
			iter_q <= iter_q - red_pkg::ITER_W'(1);
		end
		if (ctl.give) begin
			distance_q <= root_q;
		end
	end

	// Hold the result until the receiver transfers it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.give) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	assign q_pop    = ctl.q_pop;
	assign empty    = ~out_valid_q;
	assign distance = distance_q;

endmodule

>>> design/row_euclidean_distance_core.sv
// Top level of the row Euclidean distance block.
//
// Usage: items enter through a queue-style port (push / full, fields mode and
// element). A mode 0 item writes the next entry of the target vector and drops
// any partial row; a mode 1 item is the next feature of the current row. At
// the last column the row's sum of squared differences goes to the square root
// unit and the floor root appears on distance while empty is low; pop
// transfers it.
// cfg_write / cfg_data set the column count (0 acts as 1, above MAX_COLUMNS
// acts as MAX_COLUMNS); write it only while the block is idle.
// A row's last feature passes three pipeline stages, the queue, 20 root steps
// and a hold state before its result appears on distance.
// Throughput: one item per cycle while full is low; the root unit works on
// one row sum at a time, so short rows are limited by that unit, with up to
// four row sums buffered ahead of it.
// Reset clears positions, the sum, the queue and the result valid flag and
// sets the column count to 64; the target store and distance are not cleared.
// When the receiver stalls, the result holds, the root unit and queue fill,
// and full rises once four row sums are queued or in flight.
module row_euclidean_distance_core #(
	parameter int MAX_COLUMNS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic                              mode,
	input  logic signed [red_pkg::ELEM_W-1:0] element,
	output logic                              empty,
	input  logic                              pop,
	output logic [red_pkg::DIST_W-1:0]        distance,
	input  logic                              cfg_write,
	input  logic [red_pkg::CFG_W-1:0]         cfg_data
);

	red_pkg::red_push_t        qpush;
	red_pkg::red_qstat_t       qstat;
	logic [red_pkg::SUM_W-1:0] q_sum;
	logic                      q_pop;

	red_front #(
		.MAX_COLUMNS(MAX_COLUMNS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.mode      (mode),
		.element   (element),
		.cfg_write (cfg_write),
		.cfg_data  (cfg_data),
		.qstat     (qstat),
		.qpush     (qpush)
	);

	red_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.qpush  (qpush),
		.q_pop  (q_pop),
		.qstat  (qstat),
		.q_sum  (q_sum)
	);

	red_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.qstat    (qstat),
		.q_sum    (q_sum),
		.q_pop    (q_pop),
		.pop      (pop),
		.empty    (empty),
		.distance (distance)
	);

endmodule

>>> design/red_checker.sv
// Port-level checks for the row Euclidean distance block, bound to the top level.
module red_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       full,
	input logic                       empty,
	input logic                       pop,
	input logic [red_pkg::DIST_W-1:0] distance
);

	// No result is waiting right after reset
	assert property (@(posedge clk) $rose(arst_n) |-> empty)
		else $error("result waiting right after reset");

	// Nothing is outstanding right after reset, so input is open
	assert property (@(posedge clk) $rose(arst_n) |-> !full)
		else $error("full right after reset");

	// A stalled result stays and holds its value
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(distance)))
		else $error("stalled result changed or vanished");

endmodule

bind row_euclidean_distance_core red_checker u_red_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.full     (full),
	.empty    (empty),
	.pop      (pop),
	.distance (distance)
);

>>> tb/sv/tb_row_euclidean_distance_core.sv
// Self-checking testbench for the row Euclidean distance core.
`timescale 1ns / 1ps

module tb_row_euclidean_distance_core;

	localparam int MAX_COLS = 64;
	localparam logic MODE_LOAD    = 1'b0;
	localparam logic MODE_FEATURE = 1'b1;

	typedef enum logic [1:0] {
		STEP_CFG,
		STEP_LOAD,
		STEP_FEATURE
	} step_kind_t;

	typedef struct packed {
		step_kind_t                  kind;
		logic [red_pkg::CFG_W-1:0]   cols;
		logic [red_pkg::ELEM_W-1:0]  elem;
		logic                        has_dist;
		logic [red_pkg::DIST_W-1:0]  dist_want;
	} dir_step_t;

	logic                              clk;
	logic                              arst_n;
	logic                              push;
	logic                              full;
	logic                              mode;
	logic [red_pkg::ELEM_W-1:0]        element;
	logic                              empty;
	logic                              pop;
	logic [red_pkg::DIST_W-1:0]        distance;
	logic                              cfg_write;
	logic [red_pkg::CFG_W-1:0]         cfg_data;

	// Predictor state
	logic signed [red_pkg::ELEM_W-1:0] target_vec [MAX_COLS];
	bit                                target_valid [MAX_COLS];
	int unsigned                       next_load;
	int unsigned                       next_col;
	logic [63:0]                       sq_total;
	logic [red_pkg::CFG_W-1:0]         columns_cfg;
	logic [red_pkg::DIST_W-1:0]        pending_dist [$];

	int errors;
	int items_sent;
	int features_sent;
	int dist_checked;
	int settings_written;
	int full_stall_cycles;
	int send_run;
	int pop_run;
	int hold_req;
	bit hold_active;

	dir_step_t dir_table [30];

	row_euclidean_distance_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.mode      (mode),
		.element   (element),
		.empty     (empty),
		.pop       (pop),
		.distance  (distance),
		.cfg_write (cfg_write),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// Count cycles where the input side was blocked
	always @(posedge clk) begin
		if (push && full)
			full_stall_cycles++;
	end

	task automatic note_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		errors++;
	endtask

	// Draw a random wait length, with occasional runs of no waiting
	function automatic int pick_wait(inout int run);
		if (run > 0) begin
			run--;
			return 0;
		end
		if ($urandom_range(0, 5) == 0) begin
			run = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 13);
	endfunction

	function automatic int unsigned eff_columns();
		if (columns_cfg == '0)
			return 1;
		if (columns_cfg > MAX_COLS)
			return MAX_COLS;
		return columns_cfg;
	endfunction

	function automatic int unsigned cur_col();
		int unsigned cnt;
		cnt = eff_columns();
		return (next_col >= cnt) ? cnt - 1 : next_col;
	endfunction

	// Floor square root, one result bit at a time
	function automatic logic [red_pkg::DIST_W-1:0] floor_root(input logic [63:0] v);
		logic [63:0] root;
		logic [63:0] trial;
		root = '0;
		for (int b = red_pkg::DIST_W - 1; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= v)
				root = trial;
		end
		return root[red_pkg::DIST_W-1:0];
	endfunction

	function automatic logic [red_pkg::ELEM_W-1:0] rand_elem();
		logic [red_pkg::ELEM_W-1:0] e;
		case ($urandom_range(0, 7))
			0: e = 16'h7FFF;
			1: e = 16'h8000;
			2: begin
				e = $urandom_range(0, 511);
				e = e - 16'd256;
			end
			default: e = $urandom_range(0, 65535);
		endcase
		return e;
	endfunction

	// Advance the predictor by one transferred item
	task automatic predict_distance(input logic m, input logic signed [red_pkg::ELEM_W-1:0] e,
			output logic done, output logic [red_pkg::DIST_W-1:0] row_dist);
		int unsigned cnt;
		int unsigned pos;
		longint      diff;
		logic [63:0] total;
		cnt = eff_columns();
		done = 1'b0;
		row_dist = '0;
		if (m == MODE_LOAD) begin
			pos = (next_load >= cnt) ? cnt - 1 : next_load;
			target_vec[pos] = e;
			target_valid[pos] = 1'b1;
			next_load = (pos + 1 >= cnt) ? 0 : pos + 1;
			next_col = 0;
			sq_total = '0;
		end else begin
			pos = cur_col();
			diff = e - target_vec[pos];
			total = sq_total + 64'(diff * diff);
			if (total > red_pkg::SUM_MAX)
				total = red_pkg::SUM_MAX;
			if (pos + 1 >= cnt) begin
				done = 1'b1;
				row_dist = floor_root(total);
				next_col = 0;
				sq_total = '0;
			end else begin
				next_col = pos + 1;
				sq_total = total;
			end
		end
	endtask

	// Offer one item and hold it until the block takes it; push stays high
	task automatic offer_item(input logic m, input logic [red_pkg::ELEM_W-1:0] e,
			input logic use_typed, input logic [red_pkg::DIST_W-1:0] typed,
			output logic done);
		int gap;
		logic [red_pkg::DIST_W-1:0] row_dist;
		gap = pick_wait(send_run);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push    <= 1'b1;
		mode    <= m;
		element <= e;
		do @(posedge clk); while (full);
		items_sent++;
		if (m == MODE_FEATURE)
			features_sent++;
		predict_distance(m, e, done, row_dist);
		if (done)
			pending_dist = {pending_dist, (use_typed ? typed : row_dist)};
	endtask

	// Send a random feature, or a load where the target entry was never written
	task automatic offer_feature(output logic done);
		if (target_valid[cur_col()])
			offer_item(MODE_FEATURE, rand_elem(), 1'b0, '0, done);
		else
			offer_item(MODE_LOAD, rand_elem(), 1'b0, '0, done);
	endtask

	task automatic load_vector();
		logic done;
		repeat (eff_columns())
			offer_item(MODE_LOAD, rand_elem(), 1'b0, '0, done);
	endtask

	// Drop push and wait until every expected result is in
	task automatic hold_until_drained();
		push <= 1'b0;
		do @(posedge clk); while (pending_dist.size() != 0);
	endtask

	// Write the column count once the block has gone quiet
	task automatic write_columns(input logic [red_pkg::CFG_W-1:0] cols);
		hold_until_drained();
		repeat (40) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_data  <= cols;
		@(posedge clk);
		cfg_write <= 1'b0;
		columns_cfg = cols;
		settings_written++;
	endtask

	task automatic check_distance(input logic [red_pkg::DIST_W-1:0] got);
		logic [red_pkg::DIST_W-1:0] want;
		if (pending_dist.size() == 0) begin
			note_mismatch($sformatf("distance %0d with none expected", got));
		end else begin
			want = pending_dist.pop_front();
			dist_checked++;
			if (got !== want)
				note_mismatch($sformatf("distance %0d, expected %0d", got, want));
		end
	endtask

	// Result side: random stalls, plus long hold-offs on request
	initial begin : result_side
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req > 0) begin
				pop <= 1'b0;
				hold_active = 1'b1;
				repeat (hold_req) @(posedge clk);
				hold_req = 0;
				hold_active = 1'b0;
			end else begin
				stall = pick_wait(pop_run);
				if (stall > 0) begin
					pop <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				pop <= 1'b1;
				do @(posedge clk); while (empty && hold_req == 0);
				if (!empty)
					check_distance(distance);
			end
		end
	end

	initial begin : stimulus
		logic [red_pkg::CFG_W-1:0] phase_cols [10];
		logic done;
		int base;
		int k;
		int r;
		bit paused;

		push      = 1'b0;
		mode      = MODE_LOAD;
		element   = '0;
		pop       = 1'b0;
		cfg_write = 1'b0;
		cfg_data  = '0;
		arst_n    = 1'b0;
		next_load = 0;
		next_col  = 0;
		sq_total  = '0;
		columns_cfg = red_pkg::COLUMN_COUNT_RST;
		hold_req  = 0;
		hold_active = 1'b0;
		paused    = 1'b0;
		foreach (target_valid[i]) begin
			target_valid[i] = 1'b0;
			target_vec[i] = '0;
		end

		// Extremes at one column, zero count, load mid-row, count lowered mid-row
		dir_table = '{
			'{STEP_CFG,     7'd1, 16'h0000, 1'b0, 20'd0},
			'{STEP_LOAD,    7'd0, 16'h0000, 1'b0, 20'd0},
			'{STEP_FEATURE, 7'd0, 16'h7FFF, 1'b1, 20'd32767},
			'{STEP_FEATURE, 7'd0, 16'h8000, 1'b1, 20'd32768},
			'{STEP_FEATURE, 7'd0, 16'h0000, 1'b1, 20'd0},
			'{STEP_LOAD,    7'd0, 16'h8000, 1'b0, 20'd0},
			'{STEP_FEATURE, 7'd0, 16'h7FFF, 1'b1, 20'd65535},
			'{STEP_FEATURE, 7'd0, 16'h8000, 1'b1, 20'd0},
			'{STEP_LOAD,    7'd0, 16'h7FFF, 1'b0, 20'd0},
			'{STEP_FEATURE, 7'd0, 16'h8000, 1'b1, 20'd65535},
			'{STEP_CFG,     7'd0, 16'h0000, 1'b0, 20'd0},
			'{STEP_LOAD,    7'd0, 16'h0100, 1'b0, 20'd0},
			'{STEP_FEATURE, 7'd0, 16'h0300, 1'b1, 20'd512},
			'{STEP_CFG,     7'd4, 16'h0000, 1'b0, 20'd0},
			'{STEP_LOAD,    7'd0, 16'h0100, 1'b0, 20'd0},
			'{STEP_LOAD,    7'd0, 16'hFF00, 1'b0, 20'd0},
			'{STEP_LOAD,    7'd0, 16'h0000, 1'b0, 20'd0},
			'{STEP_LOAD,    7'd0, 16'h0080, 1'b0, 20'd0},
			'{STEP_FEATURE, 7'd0, 16'h0200, 1'b0, 20'd0},
			'{STEP_FEATURE, 7'd0, 16'h0000, 1'b0, 20'd0},
			'{STEP_LOAD,    7'd0, 16'h0000, 1'b0, 20'd0},
			'{STEP_FEATURE, 7'd0, 16'h7FFF, 1'b0, 20'd0},
			'{STEP_FEATURE, 7'd0, 16'h8000, 1'b0, 20'd0},
			'{STEP_FEATURE, 7'd0, 16'h0100, 1'b0, 20'd0},
			'{STEP_FEATURE, 7'd0, 16'h1234, 1'b0, 20'd0},
			'{STEP_FEATURE, 7'd0, 16'h0000, 1'b0, 20'd0},
			'{STEP_FEATURE, 7'd0, 16'h0000, 1'b0, 20'd0},
			'{STEP_FEATURE, 7'd0, 16'h0000, 1'b0, 20'd0},
			'{STEP_CFG,     7'd2, 16'h0000, 1'b0, 20'd0},
			'{STEP_FEATURE, 7'd0, 16'h0040, 1'b0, 20'd0}
		};
		phase_cols = '{7'd64, 7'd127, 7'd1, 7'd0, 7'd3, 7'd22, 7'd2, 7'd9, 7'd5, 7'd21};

		// Hold reset, then release on a clock edge
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed steps
		foreach (dir_table[i]) begin
			case (dir_table[i].kind)
				STEP_CFG: begin
					write_columns(dir_table[i].cols);
				end
				STEP_LOAD: begin
					offer_item(MODE_LOAD, dir_table[i].elem, 1'b0, '0, done);
				end
				default: begin
					offer_item(MODE_FEATURE, dir_table[i].elem, dir_table[i].has_dist,
						dir_table[i].dist_want, done);
				end
			endcase
		end

		// Random phases, one per column setting
		foreach (phase_cols[p]) begin
			write_columns(phase_cols[p]);
			load_vector();
			// Hold off the result side so the block fills and blocks input
			if (phase_cols[p] == 7'd2) begin
				hold_req = 400;
				push <= 1'b0;
				do @(posedge clk); while (!hold_active);
			end
			base = items_sent;
			while (items_sent - base < 40) begin
				if (phase_cols[p] == 7'd9 && !paused && items_sent - base >= 20) begin
					hold_until_drained();
					paused = 1'b1;
				end
				r = $urandom_range(0, 9);
				if (r == 0) begin
					load_vector();
				end else if (r == 1) begin
					// Broken row: some features, then a load drops it
					k = $urandom_range(1, eff_columns());
					repeat (k) offer_feature(done);
					offer_item(MODE_LOAD, rand_elem(), 1'b0, '0, done);
				end else begin
					done = 1'b0;
					while (!done)
						offer_feature(done);
				end
			end
		end

		// Drain, then allow the root unit to settle
		hold_until_drained();
		repeat (60) @(posedge clk);

		$display("Sent %0d items (%0d features) across %0d column settings", items_sent,
			features_sent, settings_written);
		$display("Compared %0d distances; input blocked by full for %0d cycles",
			dist_checked, full_stall_cycles);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> filelist.f
design/red_pkg.sv
design/red_front.sv
design/red_queue.sv
design/red_back.sv
design/row_euclidean_distance_core.sv
design/red_checker.sv
tb/sv/tb_row_euclidean_distance_core.sv
